@@ rtl/core/ucu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucu_pkg
// Shared widths, codes and types of the upwind cell update unit.
// ----------------------------------------------------------------------------
package ucu_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int WORD_BITS  = 32;
  localparam int ACC_BITS   = WORD_BITS + 8;
  localparam int TS_BITS    = WORD_BITS - 1;
  localparam int AREA_BITS  = WORD_BITS - 1;
  localparam int IFRAC_BITS = FRAC_BITS + 1;

  // shared multiplier: signed, one bit wider than a word
  localparam int MUL_BITS   = WORD_BITS + 1;
  localparam int PROD_BITS  = 2 * MUL_BITS;

  // |flux_sum| * time_step is formed from two partial products
  localparam int MAG_LO     = ACC_BITS / 2;
  localparam int MAG_HI     = ACC_BITS - MAG_LO;
  localparam int PLO_BITS   = MAG_LO + TS_BITS;
  localparam int PHI_BITS   = MAG_HI + TS_BITS;
  localparam int DVD_BITS   = ACC_BITS + TS_BITS;

  // quotient bits kept; anything at or above 2^Q_BITS saturates the result
  localparam int Q_BITS     = WORD_BITS + 1;
  localparam int DIV_CNT_BITS = $clog2(Q_BITS);

  localparam int CFG_AW     = 5;

  localparam logic [2:0] KIND_NORMAL   = 3'd0;
  localparam logic [2:0] KIND_LEAK     = 3'd1;
  localparam logic [2:0] KIND_INJECTOR = 3'd2;
  localparam logic [2:0] KIND_PRODUCER = 3'd3;

  localparam logic [2:0] REG_TIME_STEP     = 3'd0;
  localparam logic [2:0] REG_INJECTOR_FLUX = 3'd1;
  localparam logic [2:0] REG_INJECT_FRAC   = 3'd2;
  localparam logic [2:0] REG_ALPHA_LOW     = 3'd3;
  localparam logic [2:0] REG_ALPHA_HIGH    = 3'd4;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

@@ rtl/core/ucu_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucu_divider
// Restoring divider, one quotient bit per cycle, with overflow detect.
// ----------------------------------------------------------------------------
module ucu_divider
  import ucu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DVD_BITS-1:0]   dividend,
  input  logic [AREA_BITS-1:0]  divisor,
  output logic [Q_BITS-1:0]     quotient,
  output div_stat_t             stat
);

  logic [AREA_BITS-1:0]    rem_r, rem_nxt;
  logic [Q_BITS-1:0]       shq_r, shq_nxt;
  logic [DIV_CNT_BITS-1:0] cnt_r;
  logic                    busy_r, done_r, ovf_r;
  logic [AREA_BITS:0]      trial, diff;
  logic                    ge;

  // dividend bits shift out at the top while quotient bits shift in below
  assign trial = {rem_r, shq_r[Q_BITS-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_comb begin
    rem_nxt = ge ? diff[AREA_BITS-1:0] : trial[AREA_BITS-1:0];
    shq_nxt = {shq_r[Q_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_BITS'(Q_BITS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // high part already >= divisor: quotient needs more than Q_BITS bits
      ovf_r <= dividend[DVD_BITS-1:Q_BITS] >=
               {{(DVD_BITS-Q_BITS-AREA_BITS){1'b0}}, divisor};
      rem_r <= dividend[Q_BITS+AREA_BITS-1:Q_BITS];
      shq_r <= dividend[Q_BITS-1:0];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      shq_r <= shq_nxt;
    end
  end

  assign quotient  = shq_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;

endmodule

@@ rtl/core/upwind_cell_update_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upwind_cell_update_unit
// First-order upwind alpha update of one cell from its edge words.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one cell edge per word. Each edge's upwind flux
//   term goes through the shared 33x33 multiplier and is added to a 40-bit
//   saturating sum. A word with in_last_edge high closes the cell and makes
//   one out_ word: clamp(cell_alpha - time_step*sum/cell_area).
//   An edge that is not last passes accept, multiply and accumulate. A last
//   edge goes on to a valid result through two more multiplier passes for
//   the wide product, then the bit-serial divider, one quotient bit per
//   cycle. in_ready is low meanwhile. The result sits in an output register,
//   so the next cell's edges are taken while it waits; a cell close waits
//   only if that register is still full. Stalling out_ready never drops or
//   repeats a word.
//   Reset (rst_n, synchronous) clears the sum, the inflow flag and the
//   registers to their defaults (alpha_high = 1.0). Configuration goes through
//   APB, register i at byte address 4*i; the user must write only while idle.
// ----------------------------------------------------------------------------
module upwind_cell_update_unit
  import ucu_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  // edge words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [WORD_BITS-1:0]   in_edge_flux,
  input  logic [2:0]                    in_edge_kind,
  input  logic signed [WORD_BITS-1:0]   in_own_alpha,
  input  logic signed [WORD_BITS-1:0]   in_neighbor_alpha,
  input  logic                          in_neighbor_present,
  input  logic signed [WORD_BITS-1:0]   in_cell_alpha,
  input  logic [AREA_BITS-1:0]          in_cell_area,
  input  logic                          in_last_edge,
  // result words
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [WORD_BITS-1:0]   out_new_alpha,
  output logic                          out_clamped,
  output logic                          out_producer_inflow,
  output logic                          out_area_zero,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [CFG_AW-1:0]             paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_ACC   = 9'b000000100,
    S_P0    = 9'b000001000,
    S_P1    = 9'b000010000,
    S_SUM   = 9'b000100000,
    S_START = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  localparam int SH_BITS = PROD_BITS - FRAC_BITS;
  localparam int VW      = Q_BITS + 2;
  localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic signed [ACC_BITS-1:0]  AMAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0]  AMIN = {1'b1, {(ACC_BITS-1){1'b0}}};
  localparam logic signed [MUL_BITS-1:0]  ONE_X =
    {{(MUL_BITS-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  // configuration registers
  logic [TS_BITS-1:0]          time_step_r;
  logic signed [WORD_BITS-1:0] injector_flux_r;
  logic [IFRAC_BITS-1:0]       inject_frac_r;
  logic signed [WORD_BITS-1:0] alpha_low_r;
  logic signed [WORD_BITS-1:0] alpha_high_r;

  state_t state_r, state_nxt;

  logic signed [ACC_BITS-1:0]  flux_sum_r;
  logic                        inflow_r;
  logic signed [MUL_BITS-1:0]  op_a_r, op_b_r;
  logic signed [MUL_BITS-1:0]  op_a_nxt, op_b_nxt;
  logic signed [MUL_BITS-1:0]  mul_a, mul_b;
  logic signed [PROD_BITS-1:0] prod_r;
  logic [PLO_BITS-1:0]         plo_r;
  logic [DVD_BITS-1:0]         dividend_r;
  logic                        last_r;
  logic signed [WORD_BITS-1:0] cell_r;
  logic [AREA_BITS-1:0]        area_r;

  logic                        out_valid_r;
  logic signed [WORD_BITS-1:0] out_alpha_r;
  logic                        out_clamped_r, out_inflow_r, out_area_zero_r;

  logic [Q_BITS-1:0]           quotient;
  div_stat_t                   div_stat;
  logic                        div_start;

  logic                        in_fire, cfg_wr, fin_go;
  logic [2:0]                  cfg_idx;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r     <= '0;
      injector_flux_r <= '0;
      inject_frac_r   <= '0;
      alpha_low_r     <= '0;
      alpha_high_r    <= ONE_X[WORD_BITS-1:0];
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TIME_STEP:     time_step_r     <= pwdata[TS_BITS-1:0];
        REG_INJECTOR_FLUX: injector_flux_r <= pwdata;
        REG_INJECT_FRAC:   inject_frac_r   <= pwdata[IFRAC_BITS-1:0];
        REG_ALPHA_LOW:     alpha_low_r     <= pwdata;
        REG_ALPHA_HIGH:    alpha_high_r    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TIME_STEP:     prdata = {{(32-TS_BITS){1'b0}}, time_step_r};
      REG_INJECTOR_FLUX: prdata = injector_flux_r;
      REG_INJECT_FRAC:   prdata = {{(32-IFRAC_BITS){1'b0}}, inject_frac_r};
      REG_ALPHA_LOW:     prdata = alpha_low_r;
      REG_ALPHA_HIGH:    prdata = alpha_high_r;
      default:           prdata = '0;
    endcase
  end

  // ---------------- edge term operands ----------------
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    logic signed [MUL_BITS-1:0] flux_x, own_x, nbr_x, frac_x;
    flux_x   = {in_edge_flux[WORD_BITS-1], in_edge_flux};
    own_x    = {in_own_alpha[WORD_BITS-1], in_own_alpha};
    nbr_x    = {in_neighbor_alpha[WORD_BITS-1], in_neighbor_alpha};
    frac_x   = {{(MUL_BITS-IFRAC_BITS){1'b0}}, inject_frac_r};
    op_a_nxt = '0;
    op_b_nxt = '0;
    priority if (in_edge_kind == KIND_INJECTOR) begin
      op_a_nxt = ONE_X - frac_x;
      op_b_nxt = {injector_flux_r[WORD_BITS-1], injector_flux_r};
    end else if (in_edge_kind == KIND_PRODUCER ||
                 ((in_edge_kind == KIND_NORMAL || in_edge_kind == KIND_LEAK) &&
                  !in_edge_flux[WORD_BITS-1])) begin
      op_a_nxt = flux_x;
      op_b_nxt = own_x;
    end else if (in_edge_kind == KIND_LEAK) begin
      op_a_nxt = frac_x;
      op_b_nxt = flux_x;
    end else if (in_edge_kind == KIND_NORMAL && in_neighbor_present) begin
      op_a_nxt = flux_x;
      op_b_nxt = nbr_x;
    end else begin
      // border, unused kinds, normal inflow with no neighbor: zero term
      op_a_nxt = '0;
      op_b_nxt = '0;
    end
  end

  // ---------------- shared multiplier ----------------
  logic [ACC_BITS-1:0] mag;
  assign mag = flux_sum_r[ACC_BITS-1] ? (~flux_sum_r + 1'b1) : flux_sum_r;

  always_comb begin
    unique case (state_r)
      S_P0: begin
        mul_a = {{(MUL_BITS-MAG_LO){1'b0}}, mag[MAG_LO-1:0]};
        mul_b = {{(MUL_BITS-TS_BITS){1'b0}}, time_step_r};
      end
      S_P1: begin
        mul_a = {{(MUL_BITS-MAG_HI){1'b0}}, mag[ACC_BITS-1:MAG_LO]};
        mul_b = {{(MUL_BITS-TS_BITS){1'b0}}, time_step_r};
      end
      default: begin
        mul_a = op_a_r;
        mul_b = op_b_r;
      end
    endcase
  end

  // ---------------- accumulate ----------------
  logic signed [SH_BITS-1:0]   shifted;
  logic signed [WORD_BITS-1:0] term;
  logic signed [ACC_BITS:0]    sum_w;
  logic signed [ACC_BITS-1:0]  sum_sat;

  // dropping the low bits is the floor shift
  assign shifted = prod_r[PROD_BITS-1:FRAC_BITS];

  always_comb begin
    if ((&shifted[SH_BITS-1:WORD_BITS-1]) || !(|shifted[SH_BITS-1:WORD_BITS-1]))
      term = shifted[WORD_BITS-1:0];
    else
      term = shifted[SH_BITS-1] ? WMIN : WMAX;
    sum_w = {flux_sum_r[ACC_BITS-1], flux_sum_r} +
            {{(ACC_BITS-WORD_BITS+1){term[WORD_BITS-1]}}, term};
    if (sum_w[ACC_BITS] != sum_w[ACC_BITS-1])
      sum_sat = sum_w[ACC_BITS] ? AMIN : AMAX;
    else
      sum_sat = sum_w[ACC_BITS-1:0];
  end

  // ---------------- final update ----------------
  logic [Q_BITS:0]             dmag;
  logic signed [VW-1:0]        cell_x, value_w;
  logic signed [WORD_BITS-1:0] value, res;

  always_comb begin
    if (area_r == '0)
      dmag = '0;
    else if (div_stat.ovf)
      dmag = {1'b1, {Q_BITS{1'b0}}};
    else
      dmag = {1'b0, quotient};
    cell_x  = {{(VW-WORD_BITS){cell_r[WORD_BITS-1]}}, cell_r};
    value_w = flux_sum_r[ACC_BITS-1] ? (cell_x + {1'b0, dmag})
                                     : (cell_x - {1'b0, dmag});
    if ((&value_w[VW-1:WORD_BITS-1]) || !(|value_w[VW-1:WORD_BITS-1]))
      value = value_w[WORD_BITS-1:0];
    else
      value = value_w[VW-1] ? WMIN : WMAX;
    res = value;
    if (res < alpha_low_r)  res = alpha_low_r;
    if (res > alpha_high_r) res = alpha_high_r;
  end

  // ---------------- sequencer ----------------
  assign fin_go    = !(out_valid_r && !out_ready);
  assign div_start = (state_r == S_START);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ACC;
      S_ACC: begin
        if (!last_r)              state_nxt = S_IDLE;
        else if (area_r == '0)    state_nxt = S_FIN;
        else                      state_nxt = S_P0;
      end
      S_P0:    state_nxt = S_P1;
      S_P1:    state_nxt = S_SUM;
      S_SUM:   state_nxt = S_START;
      S_START: state_nxt = S_DIV;
      S_DIV:   if (div_stat.done) state_nxt = S_FIN;
      S_FIN:   if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      flux_sum_r  <= '0;
      inflow_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire && in_edge_kind == KIND_PRODUCER && in_edge_flux[WORD_BITS-1])
        inflow_r <= 1'b1;
      if (state_r == S_ACC)
        flux_sum_r <= sum_sat;
      if (out_valid_r && out_ready)
        out_valid_r <= 1'b0;
      if (state_r == S_FIN && fin_go) begin
        out_valid_r <= 1'b1;
        flux_sum_r  <= '0;
        inflow_r    <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_a_r <= op_a_nxt;
      op_b_r <= op_b_nxt;
      last_r <= in_last_edge;
      cell_r <= in_cell_alpha;
      area_r <= in_cell_area;
    end
    if (state_r == S_MUL || state_r == S_P0 || state_r == S_P1)
      prod_r <= mul_a * mul_b;
    if (state_r == S_P1)
      plo_r <= prod_r[PLO_BITS-1:0];
    if (state_r == S_SUM)
      dividend_r <= {{(DVD_BITS-PLO_BITS){1'b0}}, plo_r} +
                    {prod_r[PHI_BITS-1:0], {MAG_LO{1'b0}}};
    if (state_r == S_FIN && fin_go) begin
      out_alpha_r     <= res;
      out_clamped_r   <= (res != value);
      out_inflow_r    <= inflow_r;
      out_area_zero_r <= (area_r == '0);
    end
  end

  ucu_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend_r),
    .divisor  (area_r),
    .quotient (quotient),
    .stat     (div_stat)
  );

  assign out_valid           = out_valid_r;
  assign out_new_alpha       = out_alpha_r;
  assign out_clamped         = out_clamped_r;
  assign out_producer_inflow = out_inflow_r;
  assign out_area_zero       = out_area_zero_r;

`ifndef SYNTHESIS
  // divider only runs while the sequencer waits on it
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (div_stat.busy || div_stat.done) |-> (state_r == S_DIV))
    else $error("divider active outside S_DIV");

  // an accepted edge goes straight to the multiplier
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_MUL))
    else $error("accepted word not sent to multiplier");

  // a new result word appears only from the final state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result word not from S_FIN");
`endif

endmodule
